FILE: sv/ipsrn_pkg.sv
package ipsrn_pkg;

  localparam int STORE_DEPTH      = 64;
  localparam int MAX_OPTION_BYTES = 40;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  // wide enough for an option length byte and for a remaining count plus one
  localparam int CMP_W  = (CNT_W + 1 > 9) ? CNT_W + 1 : 9;

  localparam logic [7:0] OPT_END    = 8'h00;
  localparam logic [7:0] OPT_NOOP   = 8'h01;
  localparam logic [7:0] OPT_LOOSE  = 8'h83;
  localparam logic [7:0] OPT_STRICT = 8'h89;

  localparam logic [7:0] MIN_OPT_LEN   = 8'd2;
  localparam logic [7:0] MIN_ROUTE_LEN = 8'd7;
  localparam logic [7:0] ADDR_BYTES    = 8'd4;

endpackage

FILE: sv/ip_option_source_route_normalizer_unit.sv
// channel   ports                                       handshake
// --------  ------------------------------------------  -----------------------------------
// input     data_byte[7:0], last                        taken when start && !busy
// result    out_byte[7:0], status, end_of_result        one cycle per transaction on strobe
//
// a byte without last is stored while the store has room, and busy stays low.
// after the last byte the option walk takes each stored byte through a registered read of the
// option store (S_WRD), then decode and compacted write back (S_WPROC).
// results follow: 4 first-hop bytes at one a cycle, then the option bytes, each after its
// store read; an invalid list gives a single result. busy drops with the last one.
// rst is synchronous and clears the sequencer and counters; the store needs no clearing.
// the receiver cannot stall, so no result waits.
module ip_option_source_route_normalizer_unit
  import ipsrn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] data_byte,
  input  logic       last,
  output logic       strobe,
  output logic [7:0] out_byte,
  output logic       status,
  output logic       end_of_result
);

  typedef enum logic [2:0] {
    S_IDLE, S_WRD, S_WPROC, S_HOP, S_ORD, S_OEM, S_BAD
  } state_t;

  typedef enum logic [1:0] {
    M_OP, M_LEN, M_BODY, M_TAIL
  } mode_t;

  state_t             state;
  mode_t              mode, mode_next;
  logic [CNT_W-1:0]   byte_count;
  logic               overflow_flag;
  logic [CNT_W-1:0]   nbytes;
  logic [CNT_W-1:0]   rd_pos;
  logic [CNT_W-1:0]   wr_pos;
  logic [31:0]        first_hop_word, first_hop_word_next;
  logic               is_route, is_route_next;
  logic [7:0]         body_len, body_len_next;
  logic [7:0]         body_idx, body_idx_next;
  logic [1:0]         hop_idx;

  logic [7:0]         mem [STORE_DEPTH];
  logic [7:0]         rd_data;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [7:0]         mem_wd;

  logic               stored;
  logic [CNT_W-1:0]   n_next;
  logic               ovf_next;
  logic [CNT_W-1:0]   remain;
  logic [CMP_W-1:0]   limit;
  logic               walk_bad;
  logic               walk_wr;
  logic [7:0]         walk_val;

  assign busy     = (state != S_IDLE);
  assign stored   = (byte_count < CNT_W'(STORE_DEPTH));
  assign n_next   = byte_count + CNT_W'(stored);
  assign ovf_next = overflow_flag | ~stored;
  assign remain   = nbytes - rd_pos;
  assign limit    = CMP_W'(remain) + CMP_W'(1);

  // one decode step of the option walk on the byte just read
  always_comb begin
    mode_next           = mode;
    is_route_next       = is_route;
    body_len_next       = body_len;
    body_idx_next       = body_idx;
    first_hop_word_next = first_hop_word;
    walk_bad            = 1'b0;
    walk_wr             = 1'b1;
    walk_val            = rd_data;
    case (mode)
      M_OP: begin
        if (rd_data == OPT_END) begin
          mode_next = M_TAIL;
        end else if (rd_data == OPT_NOOP) begin
          mode_next = M_OP;
        end else if (remain < CNT_W'(2)) begin
          walk_bad = 1'b1;
        end else begin
          is_route_next = (rd_data == OPT_LOOSE) || (rd_data == OPT_STRICT);
          mode_next     = M_LEN;
        end
      end
      M_LEN: begin
        if (rd_data < MIN_OPT_LEN || CMP_W'(rd_data) > limit ||
            (is_route && rd_data < MIN_ROUTE_LEN)) begin
          walk_bad = 1'b1;
        end else begin
          if (is_route) walk_val = rd_data - ADDR_BYTES;
          body_len_next = rd_data - MIN_OPT_LEN;
          body_idx_next = 8'd0;
          mode_next     = (rd_data == MIN_OPT_LEN) ? M_OP : M_BODY;
        end
      end
      M_BODY: begin
        // option bytes 3..6 of a source route hold the first hop
        if (is_route && body_idx >= 8'd1 && body_idx <= ADDR_BYTES) begin
          walk_wr             = 1'b0;
          first_hop_word_next = {first_hop_word[23:0], rd_data};
        end
        body_idx_next = body_idx + 8'd1;
        if (body_idx + 8'd1 == body_len) mode_next = M_OP;
      end
      default: begin
        mode_next = M_TAIL;
      end
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = byte_count[ADDR_W-1:0];
    mem_wd = data_byte;
    if (state == S_IDLE && start && stored) begin
      mem_we = 1'b1;
    end else if (state == S_WPROC && !walk_bad && walk_wr) begin
      mem_we = 1'b1;
      mem_wa = wr_pos[ADDR_W-1:0];
      mem_wd = walk_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[rd_pos[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      byte_count    <= '0;
      overflow_flag <= 1'b0;
      rd_pos        <= '0;
      wr_pos        <= '0;
      mode          <= M_OP;
      strobe        <= 1'b0;
      end_of_result <= 1'b0;
      status        <= 1'b0;
      out_byte      <= '0;
      first_hop_word <= '0;
      hop_idx       <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            byte_count    <= n_next;
            overflow_flag <= ovf_next;
            if (last) begin
              byte_count     <= '0;
              overflow_flag  <= 1'b0;
              nbytes         <= n_next;
              rd_pos         <= '0;
              wr_pos         <= '0;
              mode           <= M_OP;
              first_hop_word <= '0;
              state <= (ovf_next || n_next[1:0] != 2'b00) ? S_BAD : S_WRD;
            end
          end
        end
        S_WRD: begin
          if (rd_pos == nbytes) begin
            hop_idx <= '0;
            state   <= (wr_pos > CNT_W'(MAX_OPTION_BYTES)) ? S_BAD : S_HOP;
          end else begin
            state <= S_WPROC;
          end
        end
        S_WPROC: begin
          if (walk_bad) begin
            state <= S_BAD;
          end else begin
            mode           <= mode_next;
            is_route       <= is_route_next;
            body_len       <= body_len_next;
            body_idx       <= body_idx_next;
            first_hop_word <= first_hop_word_next;
            rd_pos         <= rd_pos + CNT_W'(1);
            if (walk_wr) wr_pos <= wr_pos + CNT_W'(1);
            state <= S_WRD;
          end
        end
        S_HOP: begin
          strobe         <= 1'b1;
          status         <= 1'b0;
          out_byte       <= first_hop_word[31:24];
          first_hop_word <= {first_hop_word[23:0], 8'h00};
          end_of_result  <= (hop_idx == 2'd3) && (wr_pos == '0);
          hop_idx        <= hop_idx + 2'd1;
          rd_pos         <= '0;
          if (hop_idx == 2'd3) state <= (wr_pos == '0) ? S_IDLE : S_ORD;
        end
        S_ORD: begin
          state <= S_OEM;
        end
        S_OEM: begin
          strobe        <= 1'b1;
          status        <= 1'b0;
          out_byte      <= rd_data;
          end_of_result <= (rd_pos + CNT_W'(1) == wr_pos);
          rd_pos        <= rd_pos + CNT_W'(1);
          state         <= (rd_pos + CNT_W'(1) == wr_pos) ? S_IDLE : S_ORD;
        end
        S_BAD: begin
          strobe        <= 1'b1;
          status        <= 1'b1;
          out_byte      <= '0;
          end_of_result <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_bad_is_single: assert property (@(posedge clk) disable iff (rst)
    (strobe && status) |-> end_of_result)
    else $error("invalid list result not marked as last");

  a_one_list_end: assert property (@(posedge clk) disable iff (rst)
    (strobe && end_of_result) |=> !strobe)
    else $error("result after end of list");

  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_WPROC) |-> (wr_pos <= rd_pos))
    else $error("compaction write overtook the walk");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(STORE_DEPTH))
    else $error("byte count past store depth");

  a_last_starts_work: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> busy)
    else $error("last byte did not start the walk");

endmodule

FILE: tb/ipsrn_route_checker.sv
module ipsrn_route_checker
  import ipsrn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [7:0] data_byte,
  input  logic       last,
  input  logic       strobe,
  input  logic [7:0] out_byte,
  input  logic       status,
  input  logic       end_of_result,
  output int         mismatches,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       invalid;
    logic       eor;
  } route_byte_t;

  route_byte_t expected_bytes[$];
  logic [7:0]  option_copy [STORE_DEPTH];
  int          copy_count;
  bit          copy_overflow;
  int          error_total;

  // walk the stored list, pull out the first hop and queue the result bytes
  task automatic normalize_options();
    int          len;
    int          pos;
    int          olen;
    int          i;
    int          k;
    bit          bad;
    bit          done;
    logic [7:0]  op;
    logic [31:0] hop;
    route_byte_t item;
    len  = copy_count;
    pos  = 0;
    olen = 0;
    hop  = '0;
    done = 1'b0;
    bad  = copy_overflow || (len % 4 != 0);
    while (!bad && !done && pos < len) begin
      op = option_copy[pos];
      if (op == OPT_END) begin
        done = 1'b1;
      end else begin
        if (op == OPT_NOOP) begin
          olen = 1;
        end else if (len - pos < 2) begin
          bad = 1'b1;
        end else begin
          olen = option_copy[pos + 1];
          if (olen < MIN_OPT_LEN || olen > len - pos) bad = 1'b1;
        end
        if (!bad && (op == OPT_LOOSE || op == OPT_STRICT)) begin
          if (olen < MIN_ROUTE_LEN) begin
            bad = 1'b1;
          end else begin
            olen = olen - ADDR_BYTES;
            option_copy[pos + 1] = olen[7:0];
            hop = {option_copy[pos + 3], option_copy[pos + 4],
                   option_copy[pos + 5], option_copy[pos + 6]};
            // close the gap left by the removed address
            for (i = pos + 3; i + 4 < len; i++) option_copy[i] = option_copy[i + 4];
            len = len - ADDR_BYTES;
          end
        end
        pos = pos + olen;
      end
    end
    if (bad || len + 4 > MAX_OPTION_BYTES + 4) begin
      item.data    = 8'h00;
      item.invalid = 1'b1;
      item.eor     = 1'b1;
      expected_bytes.push_back(item);
    end else begin
      for (k = 0; k < len + 4; k++) begin
        item.data    = (k < 4) ? hop[31 - 8 * k -: 8] : option_copy[k - 4];
        item.invalid = 1'b0;
        item.eor     = (k == len + 3);
        expected_bytes.push_back(item);
      end
    end
    copy_count    = 0;
    copy_overflow = 1'b0;
  endtask

  always @(posedge clk) begin
    route_byte_t want;
    if (rst) begin
      expected_bytes.delete();
      copy_count    = 0;
      copy_overflow = 1'b0;
      error_total   = 0;
    end else begin
      if (strobe) begin
        if (expected_bytes.size() == 0) begin
          error_total++;
          if (error_total <= 10)
            $display("%0t: result with nothing expected: out_byte %02h status %0b end %0b",
                     $realtime, out_byte, status, end_of_result);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data || status !== want.invalid ||
              end_of_result !== want.eor) begin
            error_total++;
            if (error_total <= 10)
              $display("%0t: result mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                       $realtime, want.data, want.invalid, want.eor,
                       out_byte, status, end_of_result);
          end
        end
      end
      if (start && !busy) begin
        if (copy_count < STORE_DEPTH) begin
          option_copy[copy_count] = data_byte;
          copy_count++;
        end else begin
          copy_overflow = 1'b1;
        end
        if (last) normalize_options();
      end
    end
    mismatches  <= error_total;
    outstanding <= expected_bytes.size();
  end

endmodule

FILE: tb/tb_ip_option_source_route_normalizer_unit.sv
module tb_ip_option_source_route_normalizer_unit
  import ipsrn_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         RANDOM_BYTES   = 24;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam logic [7:0] OPT_TIMESTAMP  = 8'h44;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [7:0] data_byte;
  logic       last;
  logic       strobe;
  logic [7:0] out_byte;
  logic       status;
  logic       end_of_result;
  int         mismatches;
  int         outstanding;

  logic [7:0] list_q[$];
  int         burst_left;
  bit         steady;
  int         idle_cycles;

  ip_option_source_route_normalizer_unit u_top (.*);

  ipsrn_route_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .data_byte     (data_byte),
    .last          (last),
    .strobe        (strobe),
    .out_byte      (out_byte),
    .status        (status),
    .end_of_result (end_of_result),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ip_option_source_route_normalizer_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!steady) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 4);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    start     <= 1'b1;
    data_byte <= value;
    last      <= is_last;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_list();
    int i;
    for (i = 0; i < list_q.size(); i++) send_byte(list_q[i], i == list_q.size() - 1);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // a list of well-formed options with random content
  task automatic build_route_list();
    int         target;
    int         room;
    int         sel;
    int         olen;
    int         j;
    logic [7:0] kind;
    target = ($urandom_range(0, 9) == 0) ? 44 : 4 * $urandom_range(1, 10);
    list_q = {};
    while (list_q.size() < target) begin
      room = target - list_q.size();
      sel  = $urandom_range(0, 9);
      if (sel < 2 || room < 2) begin
        list_q.push_back(OPT_NOOP);
      end else if (sel < 6 && room >= 7) begin
        olen = $urandom_range(7, (room < 15) ? room : 15);
        list_q.push_back($urandom_range(0, 1) ? OPT_LOOSE : OPT_STRICT);
        list_q.push_back(olen[7:0]);
        for (j = 2; j < olen; j++) list_q.push_back(8'($urandom_range(0, 255)));
      end else if (sel < 9) begin
        olen = $urandom_range(2, (room < 8) ? room : 8);
        kind = 8'($urandom_range(0, 255));
        if (kind == OPT_END || kind == OPT_NOOP || kind == OPT_LOOSE || kind == OPT_STRICT)
          kind = OPT_TIMESTAMP;
        list_q.push_back(kind);
        list_q.push_back(olen[7:0]);
        for (j = 2; j < olen; j++) list_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        // bytes after end-of-list are not decoded but kept as they are
        list_q.push_back(OPT_END);
        for (j = 1; j < room; j++) list_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic build_broken_list();
    int j;
    int n;
    case ($urandom_range(0, 2))
      0: begin
        n = $urandom_range(1, 16);
        list_q = {};
        for (j = 0; j < n; j++) list_q.push_back(8'($urandom_range(0, 255)));
      end
      1: begin
        build_route_list();
        list_q[$urandom_range(0, list_q.size() - 1)] = 8'($urandom_range(0, 255));
      end
      default: begin
        build_route_list();
        if ($urandom_range(0, 1)) list_q.delete($urandom_range(0, list_q.size() - 1));
        else list_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  initial begin
    int random_bytes;
    int j;
    rst        <= 1'b1;
    start      <= 1'b0;
    data_byte  <= 8'h00;
    last       <= 1'b0;
    burst_left  = 0;
    steady      = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // loose then strict route, the last one gives the first hop
    list_q = {OPT_LOOSE, 8'd7, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              OPT_STRICT, 8'd7, 8'h04, 8'h00, 8'h00, 8'h00, 8'h01, OPT_END, 8'h00};
    send_list();
    // length not a multiple of four
    list_q = {8'hFF, 8'hFF, 8'hFF};
    send_list();
    // option length below two
    list_q = {OPT_TIMESTAMP, 8'd1, 8'h00, 8'h00};
    send_list();
    // route option shorter than seven
    list_q = {OPT_STRICT, 8'd6, 8'h04, 8'h0A, 8'h0B, 8'h0C, OPT_NOOP, OPT_END};
    send_list();
    // no-ops, then end-of-list with a trailing byte kept
    list_q = {OPT_NOOP, OPT_NOOP, OPT_END, 8'h5A};
    send_list();
    wait_drain();

    // store overflow
    list_q = {};
    for (j = 0; j < STORE_DEPTH + 2; j++) list_q.push_back(OPT_NOOP);
    send_list();
    // result too long with no route to shrink it
    list_q = {};
    for (j = 0; j < MAX_OPTION_BYTES + 8; j++) list_q.push_back(OPT_NOOP);
    send_list();

    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) build_broken_list();
      else build_route_list();
      send_list();
      random_bytes += list_q.size();
      if ($urandom_range(0, 7) == 0) wait_drain();
    end

    wait_drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("ip_option_source_route_normalizer_unit test passed");
    end else begin
      $display("ip_option_source_route_normalizer_unit test failed");
    end
    $finish;
  end

endmodule
